// ----- hdl/spf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

  // Width of the value to factor and of the resulting sum.
  localparam int VALUE_WIDTH = 32;
  // The trial divisor never passes floor(sqrt(2**VALUE_WIDTH)) + 1.
  localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;
  // Step counter of the divider, counts 0 .. VALUE_WIDTH-1.
  localparam int COUNT_WIDTH = $clog2(VALUE_WIDTH + 1);
  // Stream data width, rounded up to whole bytes.
  localparam int TDATA_WIDTH = ((VALUE_WIDTH + 7) / 8) * 8;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [DIV_WIDTH-1:0] divisor_t;

  typedef struct packed {
    logic     start;
    value_t   dividend;
    divisor_t divisor;
  } div_req_t;

  typedef struct packed {
    logic     done;
    value_t   quotient;
    divisor_t remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hdl/sum_of_prime_factors_unit.sv -----
// Sum of prime factors with multiplicity, found by trial division.
// Inputs 0 and 1 skip the divider and go straight to the output register;
// any other input runs one trial division after another, all on the one
// shared divider. One request at a time: the next is taken once the result
// moves to the output register. Synchronous active-high reset empties all
// stages.
`timescale 1ns / 1ps
`default_nettype none

module sum_of_prime_factors_unit (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // s_tdata fields from bit 0 up: value, then zero padding.
  input  wire logic [spf_pkg::TDATA_WIDTH-1:0] s_tdata,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // m_tdata fields from bit 0 up: factor_sum, then zero padding.
  output logic [spf_pkg::TDATA_WIDTH-1:0]      m_tdata
);

  spf_pkg::div_req_t div_req;
  spf_pkg::div_rsp_t div_rsp;

  logic              res_valid;
  logic              res_ready;
  spf_pkg::value_t   res_sum;
  spf_pkg::value_t   out_sum;

  // The output register takes a finished sum whenever it is empty or being
  // drained, so the sequencer can start the next request while a result
  // still waits on the master side.
  assign res_ready = !m_tvalid || m_tready;

  spf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_value  (s_tdata[spf_pkg::VALUE_WIDTH-1:0]),
    .in_ready  (s_tready),
    .res_valid (res_valid),
    .res_sum   (res_sum),
    .res_ready (res_ready),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  // The one arithmetic unit: it yields quotient and remainder of the
  // remaining cofactor by the current candidate divisor.
  spf_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
      if (res_valid) begin
        out_sum <= res_sum;
      end
    end
  end

  assign m_tdata = spf_pkg::TDATA_WIDTH'(out_sum);

endmodule

`default_nettype wire

// ----- hdl/spf_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Restoring radix-2 divider, one quotient bit per cycle.
module spf_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire spf_pkg::div_req_t req,
  output spf_pkg::div_rsp_t      rsp
);

  logic                            running;
  logic                            done;
  logic [spf_pkg::COUNT_WIDTH-1:0] count;
  spf_pkg::value_t                 quo;
  spf_pkg::divisor_t               part;
  spf_pkg::divisor_t               div;

  logic [spf_pkg::DIV_WIDTH:0]     trial;
  logic [spf_pkg::DIV_WIDTH:0]     diff;
  logic                            fits;
  spf_pkg::divisor_t               part_next;

  always_comb begin
    trial = {part, quo[spf_pkg::VALUE_WIDTH-1]};
    fits  = (trial >= {1'b0, div});
    diff  = trial - {1'b0, div};
    if (fits) begin
      part_next = diff[spf_pkg::DIV_WIDTH-1:0];
    end else begin
      part_next = trial[spf_pkg::DIV_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !running) begin
        running <= 1'b1;
        count   <= '0;
        quo     <= req.dividend;
        part    <= '0;
        div     <= req.divisor;
      end else if (running) begin
        quo  <= {quo[spf_pkg::VALUE_WIDTH-2:0], fits};
        part <= part_next;
        if (count == spf_pkg::COUNT_WIDTH'(spf_pkg::VALUE_WIDTH - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = part;

endmodule

`default_nettype wire

// ----- hdl/spf_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Trial-division sequencer around the shared divider.
module spf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire spf_pkg::value_t   in_value,
  output logic                   in_ready,
  output logic                   res_valid,
  output spf_pkg::value_t        res_sum,
  input  wire logic              res_ready,
  output spf_pkg::div_req_t      div_req,
  input  wire spf_pkg::div_rsp_t div_rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT,
    S_DONE
  } state_t;

  state_t            state;
  logic              start;
  spf_pkg::value_t   remaining;
  spf_pkg::divisor_t trial_divisor;
  spf_pkg::value_t   running_sum;

  logic              below_root;

  // The search ends once the quotient drops below the divisor (d*d > rem).
  assign below_root = (div_rsp.quotient <
                       spf_pkg::VALUE_WIDTH'(trial_divisor));

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      start         <= 1'b0;
      remaining     <= '0;
      trial_divisor <= '0;
      running_sum   <= '0;
    end else begin
      start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            remaining     <= in_value;
            trial_divisor <= spf_pkg::DIV_WIDTH'(2);
            running_sum   <= '0;
            if (in_value >= spf_pkg::VALUE_WIDTH'(2)) begin
              start <= 1'b1;
              state <= S_WAIT;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            if (below_root) begin
              if (remaining > spf_pkg::VALUE_WIDTH'(1)) begin
                running_sum <= running_sum + remaining;
              end
              state <= S_DONE;
            end else if (div_rsp.remainder == '0) begin
              remaining   <= div_rsp.quotient;
              running_sum <= running_sum + spf_pkg::VALUE_WIDTH'(trial_divisor);
              start       <= 1'b1;
            end else begin
              trial_divisor <= trial_divisor + 1'b1;
              start         <= 1'b1;
            end
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);
  assign res_sum   = running_sum;

  assign div_req.start    = start;
  assign div_req.dividend = remaining;
  assign div_req.divisor  = trial_divisor;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 4;
  localparam int RANDOM_ITEMS = 100;
  // Random values are kept to those that need few trial divisions, so that
  // the run stays short.
  localparam int DIV_BUDGET   = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 8_000_000;

  typedef struct packed {
    spf_pkg::value_t value;
    logic            known;
    spf_pkg::value_t sum;
  } factor_row_t;

  typedef struct {
    spf_pkg::value_t value;
    spf_pkg::value_t sum;
  } factor_sum_t;

  // Directed values. The sum is typed in where it can be read off directly.
  localparam int N_DIRECTED = 18;
  localparam factor_row_t DIRECTED [N_DIRECTED] = '{
    '{32'd0,          1'b1, 32'd0},
    '{32'd1,          1'b1, 32'd0},
    '{32'd2,          1'b1, 32'd2},
    '{32'd3,          1'b1, 32'd3},
    '{32'd4,          1'b1, 32'd4},
    '{32'd12,         1'b1, 32'd7},
    '{32'd49,         1'b1, 32'd14},
    '{32'd1024,       1'b1, 32'd20},
    '{32'd9973,       1'b1, 32'd9973},
    '{32'd65521,      1'b1, 32'd65521},
    '{32'd65537,      1'b1, 32'd65537},
    '{32'h8000_0000,  1'b1, 32'd62},
    '{32'hFFFF_FFFF,  1'b1, 32'd65819},
    '{32'd4294836225, 1'b1, 32'd564},
    '{32'd3486784401, 1'b1, 32'd60},
    '{32'd999999,     1'b0, 32'd0},
    '{32'hAAAA_AAAA,  1'b0, 32'd0},
    '{32'hFFFF_0000,  1'b0, 32'd0}
  };

  logic                            clk      = 1'b0;
  logic                            rst      = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [spf_pkg::TDATA_WIDTH-1:0] s_tdata  = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [spf_pkg::TDATA_WIDTH-1:0] m_tdata;

  factor_row_t  value_q [$];
  factor_sum_t  pending_sums [$];
  int unsigned  next_value;
  int unsigned  burst_left;
  int unsigned  gap_left;
  int unsigned  stall_mode;
  int unsigned  stall_left;
  int unsigned  cycle_count;
  int unsigned  error_count;
  factor_sum_t  want;
  factor_sum_t  head_sum;
  int unsigned  ignored_divs;

  sum_of_prime_factors_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #(CLK_HALF) clk = ~clk;

  // Trial division with candidates 2, 3, 4, ... up to the square root of the
  // cofactor; a cofactor above one that is left over is a prime. Also
  // reports a count of the trial divisions made for this value.
  function automatic spf_pkg::value_t prime_factor_sum(input spf_pkg::value_t value,
                                                       output int unsigned divs);
    logic [63:0] rem;
    logic [63:0] acc;
    logic [63:0] cand;
    rem  = 64'(value);
    acc  = '0;
    cand = 64'd2;
    divs = 0;
    if (rem >= 64'd2) begin
      while (cand <= rem / cand) begin
        while (rem % cand == 64'd0) begin
          rem  = rem / cand;
          acc  = acc + cand;
          divs = divs + 1;
        end
        cand = cand + 64'd1;
        divs = divs + 1;
      end
      if (rem > 64'd1)
        acc = acc + rem;
    end
    return acc[spf_pkg::VALUE_WIDTH-1:0];
  endfunction

  // Draws a random value that the block factors within the division budget.
  // Most are products of small factors; the others are random bit patterns
  // of random length and small plain numbers.
  function automatic spf_pkg::value_t draw_value();
    spf_pkg::value_t value;
    logic [63:0]     prod;
    int unsigned     fac;
    int unsigned     kind;
    int unsigned     divs;
    value = spf_pkg::value_t'(360360);
    for (int attempt = 0; attempt < 400; attempt++) begin
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        value = spf_pkg::value_t'($urandom) >> $urandom_range(0, spf_pkg::VALUE_WIDTH - 1);
      end else if (kind < 8) begin
        prod = 64'd1;
        repeat ($urandom_range(1, 8)) begin
          fac = $urandom_range(2, 255);
          if (prod * fac < (64'd1 << spf_pkg::VALUE_WIDTH))
            prod = prod * fac;
        end
        prod = prod << $urandom_range(0, 3);
        if (prod >= (64'd1 << spf_pkg::VALUE_WIDTH))
          prod = prod >> 3;
        value = prod[spf_pkg::VALUE_WIDTH-1:0];
      end else begin
        value = spf_pkg::value_t'($urandom_range(0, 5000));
      end
      if (prime_factor_sum(value, divs) == spf_pkg::value_t'(0) || divs <= DIV_BUDGET)
        return value;
    end
    return spf_pkg::value_t'(360360);
  endfunction

  // Request side: bursts of random length separated by random gaps. A held
  // request stays on the bus untouched until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = $urandom_range(1, 8);
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        want.value = value_q[next_value].value;
        if (value_q[next_value].known)
          want.sum = value_q[next_value].sum;
        else
          want.sum = prime_factor_sum(want.value, ignored_divs);
        pending_sums.push_back(want);
        next_value = next_value + 1;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (next_value < value_q.size()) begin
          s_tvalid <= 1'b1;
          s_tdata  <= spf_pkg::TDATA_WIDTH'(value_q[next_value].value);
          burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: the stall pattern changes every so often between always
  // ready, ready at random, and mostly stalled.
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_mode = 0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left = stall_left - 1;
      end
      case (stall_mode)
        0: begin
          m_tready <= 1'b1;
        end
        1: begin
          m_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          m_tready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // Each accepted result is checked against the oldest pending sum.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result, factor_sum %0d", m_tdata[spf_pkg::VALUE_WIDTH-1:0]);
        error_count = error_count + 1;
      end else begin
        head_sum = pending_sums.pop_front();
        if (m_tdata[spf_pkg::VALUE_WIDTH-1:0] !== head_sum.sum) begin
          $error("factor_sum of %0d: expected %0d, actual %0d",
                 head_sum.value, head_sum.sum, m_tdata[spf_pkg::VALUE_WIDTH-1:0]);
          error_count = error_count + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    factor_row_t row;
    next_value  = 0;
    cycle_count = 0;
    error_count = 0;
    for (int i = 0; i < N_DIRECTED; i++)
      value_q.push_back(DIRECTED[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      row.value = draw_value();
      row.known = 1'b0;
      row.sum   = '0;
      value_q.push_back(row);
    end
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    wait (next_value == value_q.size() && pending_sums.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/spf_pkg.sv
hdl/spf_divider.sv
hdl/spf_ctrl.sv
hdl/sum_of_prime_factors_unit.sv
dv/tb.sv
